@@ rtl/rcls_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Road curve line scroll package
// Shared widths, codes, reset values and the curve rate tables of the
// pseudo-3D road curve generator.
// ----------------------------------------------------------------------------
package rcls_pkg;

   localparam int SCREEN_LINES_DEF  = 224;
   localparam int ROAD_SEGMENTS_DEF = 13;
   localparam int FRAC_BITS_DEF     = 6;

   localparam int DATA_W      = 16;
   localparam int OFFSET_W    = 10;
   localparam int ROW_W       = 8;
   localparam int SEG_W       = 4;
   localparam int SEG_SLOTS   = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int MILLI_SCALE = 1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEED         = 2'd0,
      CSR_FAR_DEPTH     = 2'd1,
      CSR_CENTER_OFFSET = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_LINE  = 1'b0,
      CMD_FRAME = 1'b1
   } command_type;

   typedef enum logic {
      KIND_ROAD = 1'b0,
      KIND_BACK = 1'b1
   } kind_type;

   localparam logic [DATA_W-1:0]   SPEED_RESET     = 16'hFFFA;
   localparam logic [DATA_W-1:0]   FAR_DEPTH_RESET = 16'd1600;
   localparam logic [OFFSET_W-1:0] CENTER_RESET    = 10'h3A0;
   localparam int                  BACK_START      = -96;
   localparam logic [SEG_W-1:0]    BOTTOM_RESET    = 4'd0;
   localparam logic [SEG_W-1:0]    NEXT_RESET      = 4'd1;

   // Curve rates in thousandths; slots past the defined segments are flat.
   localparam int ROAD_MILLI [SEG_SLOTS] = '{
      0, -20, -40, -20, 0, 0, 60, -60, 0, 20, 0, -30, 30, 0, 0, 0};
   localparam int BACK_MILLI [SEG_SLOTS] = '{
      0, -120, -320, -120, 0, 0, 360, -360, 0, 120, 0, -180, 180, 0, 0, 0};

   // Converts a rate in thousandths to fixed point, truncating toward zero.
   function automatic logic [DATA_W-1:0] fix_rate(input int milli, input int frac);
      return DATA_W'((milli * (1 << frac)) / MILLI_SCALE);
   endfunction

   // Integer part of a fixed point value, rounded toward minus infinity.
   function automatic logic [DATA_W-1:0] int_part(input logic [DATA_W-1:0] x,
                                                  input int frac);
      return DATA_W'($signed(x) >>> frac);
   endfunction

endpackage
`default_nettype wire

@@ rtl/rcls_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Road curve line scroll channels
// Valid/ready channels for scanline requests, scroll responses and
// register writes.
// ----------------------------------------------------------------------------
interface rcls_req_if;
   import rcls_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [DATA_W-1:0] line_depth;

   modport source (output valid, command, line_depth, input ready);
   modport sink   (input valid, command, line_depth, output ready);
endinterface

interface rcls_rsp_if;
   import rcls_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [ROW_W-1:0]  row;
   logic [DATA_W-1:0] scroll_value;

   modport source (output valid, kind, row, scroll_value, input ready);
   modport sink   (input valid, kind, row, scroll_value, output ready);
endinterface

interface rcls_csr_if;
   import rcls_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/road_curve_line_scroll.sv @@
`default_nettype none
// A request beat is held in the input register until the output register is free.
// Throughput: one request beat per cycle, sustained while responses are taken.
// Line beats update slope and offset; frame beats update the segment registers.
// Synchronous active-high reset restores state; data and payload are not reset.
// Register writes are taken in any cycle, one per cycle.
// ----------------------------------------------------------------------------
// Road curve line scroll
// Turns scanline depths into road line scroll values through slope and
// offset accumulators, and steps the background and curve segments per frame.
// ----------------------------------------------------------------------------
module road_curve_line_scroll #(
   parameter int SCREEN_LINES  = rcls_pkg::SCREEN_LINES_DEF,
   parameter int ROAD_SEGMENTS = rcls_pkg::ROAD_SEGMENTS_DEF,
   parameter int FRAC_BITS     = rcls_pkg::FRAC_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   rcls_req_if.sink        req_bus,
   rcls_rsp_if.source      rsp_bus,
   rcls_csr_if.sink        csr_bus
);
   import rcls_pkg::*;

   localparam logic [DATA_W-1:0] BACK_RESET = DATA_W'(BACK_START * (1 << FRAC_BITS));

   logic [DATA_W-1:0] road_rate [SEG_SLOTS];
   logic [DATA_W-1:0] back_rate [SEG_SLOTS];

   for (genvar i = 0; i < SEG_SLOTS; i++) begin : g_rate
      assign road_rate[i] = fix_rate(ROAD_MILLI[i], FRAC_BITS);
      assign back_rate[i] = fix_rate(BACK_MILLI[i], FRAC_BITS);
   end

   logic                in_valid_ff, in_valid_in;
   logic                in_command_ff;
   logic [DATA_W-1:0]   in_depth_ff;

   logic                out_valid_ff, out_valid_in;
   logic                out_kind_ff, out_kind_in;
   logic [ROW_W-1:0]    out_row_ff, out_row_in;
   logic [DATA_W-1:0]   out_scroll_ff, out_scroll_in;

   logic [DATA_W-1:0]   speed_ff, speed_in;
   logic [DATA_W-1:0]   far_depth_ff, far_depth_in;
   logic [OFFSET_W-1:0] center_ff, center_in;

   logic [ROW_W-1:0]    line_count_ff, line_count_in;
   logic [DATA_W-1:0]   slope_ff, slope_in;
   logic [DATA_W-1:0]   offset_ff, offset_in;
   logic [DATA_W-1:0]   seg_pos_ff, seg_pos_in;
   logic [DATA_W-1:0]   back_pos_ff, back_pos_in;
   logic [SEG_W-1:0]    bottom_ff, bottom_in;
   logic [SEG_W-1:0]    next_ff, next_in;

   logic                req_beat;
   logic                out_free;
   logic                load_out;
   logic                depth_near;
   logic [DATA_W-1:0]   line_rate;
   logic [DATA_W-1:0]   slope_sum;
   logic [DATA_W-1:0]   offset_sum;
   logic [DATA_W-1:0]   center_ext;
   logic [DATA_W-1:0]   back_sum;
   logic [DATA_W-1:0]   seg_sum;
   logic [SEG_W:0]      next_step;
   logic [ROW_W:0]      line_step;

   assign out_free       = !out_valid_ff || rsp_bus.ready;
   assign load_out       = in_valid_ff && out_free;
   assign req_bus.ready  = !in_valid_ff || out_free;
   assign req_beat       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready  = 1'b1;

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.kind         = out_kind_ff;
   assign rsp_bus.row          = out_row_ff;
   assign rsp_bus.scroll_value = out_scroll_ff;

   always_comb begin
      depth_near = $signed(in_depth_ff) < $signed(seg_pos_ff);
      line_rate  = depth_near ? road_rate[bottom_ff] : road_rate[next_ff];
      slope_sum  = slope_ff + line_rate;
      offset_sum = offset_ff + slope_sum;
      center_ext = {{(DATA_W-OFFSET_W){center_ff[OFFSET_W-1]}}, center_ff};
      back_sum   = back_pos_ff - back_rate[bottom_ff];
      seg_sum    = seg_pos_ff + speed_ff;
      next_step  = {1'b0, next_ff} + (SEG_W+1)'(1);
      line_step  = {1'b0, line_count_ff} + (ROW_W+1)'(1);
   end

   always_comb begin
      in_valid_in   = req_beat || (in_valid_ff && !out_free);
      out_valid_in  = load_out || (out_valid_ff && !rsp_bus.ready);
      out_kind_in   = out_kind_ff;
      out_row_in    = out_row_ff;
      out_scroll_in = out_scroll_ff;
      line_count_in = line_count_ff;
      slope_in      = slope_ff;
      offset_in     = offset_ff;
      seg_pos_in    = seg_pos_ff;
      back_pos_in   = back_pos_ff;
      bottom_in     = bottom_ff;
      next_in       = next_ff;

      if (load_out) begin
         if (in_command_ff == CMD_LINE) begin
            slope_in      = slope_sum;
            offset_in     = offset_sum;
            out_kind_in   = KIND_ROAD;
            out_row_in    = ROW_W'(SCREEN_LINES - 1) - line_count_ff;
            out_scroll_in = center_ext + int_part(offset_sum, FRAC_BITS);
            if (line_step >= (ROW_W+1)'(SCREEN_LINES)) begin
               line_count_in = '0;
            end else begin
               line_count_in = line_step[ROW_W-1:0];
            end
         end else begin
            back_pos_in   = back_sum;
            out_kind_in   = KIND_BACK;
            out_row_in    = '0;
            out_scroll_in = int_part(back_sum, FRAC_BITS);
            seg_pos_in    = seg_sum;
            if (seg_sum[DATA_W-1]) begin
               bottom_in  = next_ff;
               seg_pos_in = far_depth_ff;
               if (next_step >= (SEG_W+1)'(ROAD_SEGMENTS)) begin
                  next_in = '0;
               end else begin
                  next_in = next_step[SEG_W-1:0];
               end
            end
            line_count_in = '0;
            slope_in      = '0;
            offset_in     = '0;
         end
      end
   end

   always_comb begin
      speed_in     = speed_ff;
      far_depth_in = far_depth_ff;
      center_in    = center_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_SPEED:         speed_in     = csr_bus.data;
            CSR_FAR_DEPTH:     far_depth_in = csr_bus.data;
            CSR_CENTER_OFFSET: center_in    = csr_bus.data[OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         speed_ff      <= SPEED_RESET;
         far_depth_ff  <= FAR_DEPTH_RESET;
         center_ff     <= CENTER_RESET;
         line_count_ff <= '0;
         slope_ff      <= '0;
         offset_ff     <= '0;
         seg_pos_ff    <= FAR_DEPTH_RESET;
         back_pos_ff   <= BACK_RESET;
         bottom_ff     <= BOTTOM_RESET;
         next_ff       <= NEXT_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         speed_ff      <= speed_in;
         far_depth_ff  <= far_depth_in;
         center_ff     <= center_in;
         line_count_ff <= line_count_in;
         slope_ff      <= slope_in;
         offset_ff     <= offset_in;
         seg_pos_ff    <= seg_pos_in;
         back_pos_ff   <= back_pos_in;
         bottom_ff     <= bottom_in;
         next_ff       <= next_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_command_ff <= req_bus.command;
         in_depth_ff   <= req_bus.line_depth;
      end
      out_kind_ff   <= out_kind_in;
      out_row_ff    <= out_row_in;
      out_scroll_ff <= out_scroll_in;
   end

endmodule
`default_nettype wire

@@ rtl/rcls_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Road curve line scroll checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module rcls_checker #(
   parameter int SCREEN_LINES = rcls_pkg::SCREEN_LINES_DEF
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic                      rsp_kind,
   input wire logic [rcls_pkg::ROW_W-1:0]  rsp_row,
   input wire logic [rcls_pkg::DATA_W-1:0] rsp_scroll_value
);
   import rcls_pkg::*;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_back_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_BACK) |-> rsp_row == '0)
      else $error("background beat with nonzero row");

   a_road_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ROAD) |-> rsp_row <= ROW_W'(SCREEN_LINES - 1))
      else $error("road beat row beyond the screen");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_kind) && $stable(rsp_row) && $stable(rsp_scroll_value)))
      else $error("stalled response beat changed");

endmodule

bind road_curve_line_scroll rcls_checker #(
   .SCREEN_LINES(SCREEN_LINES)
) u_rcls_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_kind         (rsp_bus.kind),
   .rsp_row          (rsp_bus.row),
   .rsp_scroll_value (rsp_bus.scroll_value)
);
`default_nettype wire
